### hw/rtl/lrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lrc_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int CFG_IDX_BITS   = 4;
  localparam int NEAR_ZERO_LSB  = 16;
  localparam int DIV_STEPS      = 4;

  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_LEFT   = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_TOP    = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_RIGHT  = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_BOTTOM = CFG_IDX_BITS'(3);

endpackage
`default_nettype wire

### hw/rtl/lrc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface lrc_in_if #(
  parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source(output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink(input valid, start_x, start_y, end_x, end_y, output ready);
endinterface
`default_nettype wire

### hw/rtl/lrc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface lrc_out_if #(
  parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] seg_from_x;
  logic signed [COORD_BITS-1:0] seg_from_y;
  logic signed [COORD_BITS-1:0] seg_to_x;
  logic signed [COORD_BITS-1:0] seg_to_y;
  logic                         last_segment;
  logic                         fully_clipped;

  modport source(output valid, seg_from_x, seg_from_y, seg_to_x, seg_to_y,
                 last_segment, fully_clipped, input ready);
  modport sink(input valid, seg_from_x, seg_from_y, seg_to_x, seg_to_y,
               last_segment, fully_clipped, output ready);
endinterface
`default_nettype wire

### hw/rtl/lrc_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface lrc_cfg_if #(
  parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [lrc_pkg::CFG_IDX_BITS-1:0]  index;
  logic [COORD_BITS-1:0]             data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/lrc_sect.sv
`timescale 1ns / 1ps
`default_nettype none
module lrc_sect #(
  parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic signed [COORD_BITS-1:0] a0,
  input  wire logic signed [COORD_BITS-1:0] a1,
  input  wire logic signed [COORD_BITS-1:0] b0,
  input  wire logic signed [COORD_BITS-1:0] b1,
  input  wire logic signed [COORD_BITS-1:0] t,
  output logic signed [COORD_BITS-1:0]      res
);
  localparam int W   = COORD_BITS;
  localparam int SPS = lrc_pkg::DIV_STEPS;
  localparam int DS  = (W + SPS - 1) / SPS;

  logic signed [W:0] d, n, m, mid_sum;
  logic [W:0]        ad_f, an_f, am_f;
  logic [W-1:0]      ad_c, an_c, am_c;

  always_comb begin
    d       = {b1[W-1], b1} - {b0[W-1], b0};
    n       = {t[W-1], t} - {b0[W-1], b0};
    m       = {a1[W-1], a1} - {a0[W-1], a0};
    mid_sum = {a0[W-1], a0} + {a1[W-1], a1};
    ad_f    = d[W] ? (~d + 1'b1) : d;
    an_f    = n[W] ? (~n + 1'b1) : n;
    am_f    = m[W] ? (~m + 1'b1) : m;
    ad_c    = ad_f[W-1:0];
    am_c    = am_f[W-1:0];
    an_c    = (an_f[W-1:0] > ad_c) ? ad_c : an_f[W-1:0];
  end

  logic [W-1:0]        p1_an, p1_am, p1_ad;
  logic                p1_neg, p1_near;
  logic signed [W-1:0] p1_mid, p1_a0;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_an   <= an_c;
      p1_am   <= am_c;
      p1_ad   <= ad_c;
      p1_neg  <= n[W] ^ m[W] ^ d[W];
      p1_near <= (ad_c <= W'(lrc_pkg::NEAR_ZERO_LSB));
      p1_mid  <= mid_sum[W:1];
      p1_a0   <= a0;
    end
  end

  logic [W-1:0]        rem_q  [DS+1];
  logic [W-1:0]        work_q [DS+1];
  logic [W-1:0]        ad_q   [DS+1];
  logic                neg_q  [DS+1];
  logic                near_q [DS+1];
  logic signed [W-1:0] mid_q  [DS+1];
  logic signed [W-1:0] a0_q   [DS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      {rem_q[0], work_q[0]} <= (2*W)'(p1_an) * (2*W)'(p1_am);
      ad_q[0]   <= p1_ad;
      neg_q[0]  <= p1_neg;
      near_q[0] <= p1_near;
      mid_q[0]  <= p1_mid;
      a0_q[0]   <= p1_a0;
    end
  end

  for (genvar i = 0; i < DS; i++) begin : g_div
    logic [W-1:0] rem_n, work_n;
    logic [W:0]   trial;

    always_comb begin
      rem_n  = rem_q[i];
      work_n = work_q[i];
      trial  = '0;
      for (int j = 0; j < SPS; j++) begin
        if (i * SPS + j < W) begin
          trial = {rem_n, work_n[W-1]};
          if (trial >= {1'b0, ad_q[i]}) begin
            trial  = trial - {1'b0, ad_q[i]};
            work_n = {work_n[W-2:0], 1'b1};
          end else begin
            work_n = {work_n[W-2:0], 1'b0};
          end
          rem_n = trial[W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i+1]  <= rem_n;
        work_q[i+1] <= work_n;
        ad_q[i+1]   <= ad_q[i];
        neg_q[i+1]  <= neg_q[i];
        near_q[i+1] <= near_q[i];
        mid_q[i+1]  <= mid_q[i];
        a0_q[i+1]   <= a0_q[i];
      end
    end
  end

  localparam logic signed [W+1:0] MAXV = (W+2)'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [W+1:0] MINV = -MAXV - (W+2)'(1);

  logic signed [W+1:0] qx, sum;
  logic signed [W-1:0] res_next;

  always_comb begin
    qx  = signed'({2'b00, work_q[DS]});
    sum = {{2{a0_q[DS][W-1]}}, a0_q[DS]} + (neg_q[DS] ? -qx : qx);
    if (near_q[DS]) begin
      res_next = mid_q[DS];
    end else if (sum > MAXV) begin
      res_next = MAXV[W-1:0];
    end else if (sum < MINV) begin
      res_next = MINV[W-1:0];
    end else begin
      res_next = sum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/lrc_emit.sv
`timescale 1ns / 1ps
`default_nettype none
module lrc_emit #(
  parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         pvalid,
  output logic                              take,
  input  wire logic signed [COORD_BITS-1:0] px0,
  input  wire logic signed [COORD_BITS-1:0] py0,
  input  wire logic signed [COORD_BITS-1:0] px1,
  input  wire logic signed [COORD_BITS-1:0] py1,
  input  wire logic signed [COORD_BITS-1:0] s_top,
  input  wire logic signed [COORD_BITS-1:0] s_bottom,
  input  wire logic signed [COORD_BITS-1:0] s_left,
  input  wire logic signed [COORD_BITS-1:0] s_right,
  input  wire logic signed [COORD_BITS-1:0] clip_left,
  input  wire logic signed [COORD_BITS-1:0] clip_top,
  input  wire logic signed [COORD_BITS-1:0] clip_right,
  input  wire logic signed [COORD_BITS-1:0] clip_bottom,
  lrc_out_if.source                         seg_out
);
  localparam int W = COORD_BITS;

  logic signed [W-1:0] px [2], py [2], tx [2], ty [2];
  logic signed [W-1:0] rx [4], ry [4], ax [4], ay [4];
  logic                ylo, yhi, xlo, xhi, clipped, reverse, lclip, rclip;
  logic [2:0]          k;
  logic [1:0]          a_lines, idx;
  logic signed [W-1:0] e;

  always_comb begin
    px[0] = px0; px[1] = px1; py[0] = py0; py[1] = py1;
    ylo = !(py0 < py1);
    yhi = !ylo;
    clipped = (py[yhi] <= clip_top) || (py[ylo] >= clip_bottom);
    tx = px;
    ty = py;
    if (py[ylo] < clip_top) begin
      tx[ylo] = s_top;
      ty[ylo] = clip_top;
    end
    if (ty[yhi] > clip_bottom) begin
      tx[yhi] = s_bottom;
      ty[yhi] = clip_bottom;
    end
    xlo = !(px0 < px1);
    xhi = !xlo;
    lclip = tx[xlo] < clip_left;
    rclip = tx[xhi] > clip_right;
    for (int j = 0; j < 4; j++) begin
      rx[j] = '0;
      ry[j] = '0;
    end
    k = '0;
    reverse = 1'b0;
    e = (tx[xhi] <= clip_left) ? clip_left : clip_right;
    if (tx[xhi] <= clip_left || tx[xlo] >= clip_right) begin
      rx[0] = e; ry[0] = ty[0];
      rx[1] = e; ry[1] = ty[1];
      k = 3'd2;
    end else begin
      reverse = !xhi;
      if (lclip) begin
        rx[k[1:0]] = clip_left; ry[k[1:0]] = ty[xlo]; k = k + 3'd1;
        rx[k[1:0]] = clip_left; ry[k[1:0]] = s_left;  k = k + 3'd1;
      end else begin
        rx[k[1:0]] = tx[xlo];   ry[k[1:0]] = ty[xlo]; k = k + 3'd1;
      end
      if (rclip) begin
        rx[k[1:0]] = clip_right; ry[k[1:0]] = s_right; k = k + 3'd1;
        rx[k[1:0]] = clip_right; ry[k[1:0]] = ty[xhi]; k = k + 3'd1;
      end else begin
        rx[k[1:0]] = tx[xhi];    ry[k[1:0]] = ty[xhi]; k = k + 3'd1;
      end
    end
    a_lines = 2'(k - 3'd1);
    for (int j = 0; j < 4; j++) begin
      idx = reverse ? 2'(a_lines - 2'(j)) : 2'(j);
      ax[j] = clipped ? '0 : rx[idx];
      ay[j] = clipped ? '0 : ry[idx];
    end
    if (clipped) begin
      a_lines = 2'd1;
    end
  end

  logic signed [W-1:0] ix [4], iy [4];
  logic [1:0]          lines, s;
  logic                busy, iclip, slot_free, last_now;

  assign slot_free = !seg_out.valid || seg_out.ready;
  assign last_now  = (s == 2'(lines - 2'd1));
  assign take      = pvalid && (!busy || (slot_free && last_now));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      seg_out.valid <= 1'b0;
      s             <= '0;
    end else begin
      if (slot_free) begin
        if (busy) begin
          seg_out.valid <= 1'b1;
          if (last_now) begin
            busy <= 1'b0;
          end else begin
            s <= s + 2'd1;
          end
        end else begin
          seg_out.valid <= 1'b0;
        end
      end
      if (take) begin
        busy <= 1'b1;
        s    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && busy) begin
      seg_out.seg_from_x    <= ix[s];
      seg_out.seg_from_y    <= iy[s];
      seg_out.seg_to_x      <= ix[2'(s + 2'd1)];
      seg_out.seg_to_y      <= iy[2'(s + 2'd1)];
      seg_out.last_segment  <= last_now;
      seg_out.fully_clipped <= iclip;
    end
    if (take) begin
      ix    <= ax;
      iy    <= ay;
      lines <= a_lines;
      iclip <= clipped;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/line_rect_clip_segments.sv
// Throughput: one input per cycle while each input yields one segment and
// the output accepts every segment; an input that yields n segments holds
// the single output port until all n of them have been sent.
// The edge intersections run through a 32-step divider split over 8 stages.
// Reset (synchronous, active high) empties the pipeline and restores the
// clip rectangle to left=0, top=0, right=max, bottom=max.
`timescale 1ns / 1ps
`default_nettype none
module line_rect_clip_segments #(
  parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  lrc_cfg_if.sink   cfg,
  lrc_in_if.sink    seg_in,
  lrc_out_if.source seg_out
);
  localparam int W = COORD_BITS;
  localparam int P = (W + lrc_pkg::DIV_STEPS - 1) / lrc_pkg::DIV_STEPS + 3;
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};

  logic signed [W-1:0] clip_left, clip_top, clip_right, clip_bottom;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= '0;
      clip_top    <= '0;
      clip_right  <= CMAX;
      clip_bottom <= CMAX;
    end else if (cfg.valid) begin
      case (cfg.index)
        lrc_pkg::REG_CLIP_LEFT:   clip_left   <= cfg.data;
        lrc_pkg::REG_CLIP_TOP:    clip_top    <= cfg.data;
        lrc_pkg::REG_CLIP_RIGHT:  clip_right  <= cfg.data;
        lrc_pkg::REG_CLIP_BOTTOM: clip_bottom <= cfg.data;
        default: ;
      endcase
    end
  end

  logic                adv, take;
  logic                vld [P];
  logic signed [W-1:0] dx0 [P], dy0 [P], dx1 [P], dy1 [P];

  assign adv          = !vld[P-1] || take;
  assign seg_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < P; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= seg_in.valid;
      for (int i = 1; i < P; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx0[0] <= seg_in.start_x;
      dy0[0] <= seg_in.start_y;
      dx1[0] <= seg_in.end_x;
      dy1[0] <= seg_in.end_y;
      for (int i = 1; i < P; i++) begin
        dx0[i] <= dx0[i-1];
        dy0[i] <= dy0[i-1];
        dx1[i] <= dx1[i-1];
        dy1[i] <= dy1[i-1];
      end
    end
  end

  logic signed [W-1:0] s_top, s_bottom, s_left, s_right;

  lrc_sect #(.COORD_BITS(W)) u_top (
    .clk(clk), .en(adv),
    .a0(seg_in.start_x), .a1(seg_in.end_x), .b0(seg_in.start_y), .b1(seg_in.end_y),
    .t(clip_top), .res(s_top)
  );

  lrc_sect #(.COORD_BITS(W)) u_bottom (
    .clk(clk), .en(adv),
    .a0(seg_in.start_x), .a1(seg_in.end_x), .b0(seg_in.start_y), .b1(seg_in.end_y),
    .t(clip_bottom), .res(s_bottom)
  );

  lrc_sect #(.COORD_BITS(W)) u_left (
    .clk(clk), .en(adv),
    .a0(seg_in.start_y), .a1(seg_in.end_y), .b0(seg_in.start_x), .b1(seg_in.end_x),
    .t(clip_left), .res(s_left)
  );

  lrc_sect #(.COORD_BITS(W)) u_right (
    .clk(clk), .en(adv),
    .a0(seg_in.start_y), .a1(seg_in.end_y), .b0(seg_in.start_x), .b1(seg_in.end_x),
    .t(clip_right), .res(s_right)
  );

  lrc_emit #(.COORD_BITS(W)) u_emit (
    .clk(clk), .rst(rst),
    .pvalid(vld[P-1]), .take(take),
    .px0(dx0[P-1]), .py0(dy0[P-1]), .px1(dx1[P-1]), .py1(dy1[P-1]),
    .s_top(s_top), .s_bottom(s_bottom), .s_left(s_left), .s_right(s_right),
    .clip_left(clip_left), .clip_top(clip_top),
    .clip_right(clip_right), .clip_bottom(clip_bottom),
    .seg_out(seg_out)
  );
endmodule
`default_nettype wire
